### design/cdq_pkg.sv
// Package for the circular deque: sizes, operation and status codes,
// controller states and the command and status groups between controller
// and datapath. No dependencies.
`default_nettype none

package cdq_pkg;

  localparam int DEPTH     = 128;
  localparam int DATA_BITS = 32;
  localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WORD_W    = 32;
  localparam int FUNC_W    = 2;
  localparam int STATUS_W  = 2;

  typedef logic [PTR_W-1:0]     ptr_t;
  typedef logic [DATA_BITS-1:0] data_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_INS_FRONT,
    FN_INS_REAR,
    FN_DEL_FRONT,
    FN_DEL_REAR
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_DONE,
    STS_FULL,
    STS_EMPTY
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_LOAD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic take;
    logic rd_en;
    logic load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic need_read;
    logic out_free;
  } stat_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
  endfunction

  function automatic ptr_t ptr_dec(input ptr_t p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : ptr_t'(p - 1'b1);
  endfunction

endpackage

`default_nettype wire

### design/cdq_req_if.sv
// Request channel of the circular deque: one operation code and one data
// word per beat. Depends on cdq_pkg for the field widths.
`default_nettype none

interface cdq_req_if;
  logic                             valid;
  logic                             ready;
  logic [cdq_pkg::FUNC_W-1:0]       func;
  logic signed [cdq_pkg::WORD_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

`default_nettype wire

### design/cdq_rsp_if.sv
// Response channel of the circular deque: front and rear entries, flags
// and status per beat. Depends on cdq_pkg for the field widths.
`default_nettype none

interface cdq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [cdq_pkg::WORD_W-1:0] front_value;
  logic signed [cdq_pkg::WORD_W-1:0] rear_value;
  logic                              is_empty;
  logic                              is_full;
  logic [cdq_pkg::STATUS_W-1:0]      status;

  modport source (output valid, output front_value, output rear_value,
                  output is_empty, output is_full, output status, input ready);
  modport sink   (input valid, input front_value, input rear_value,
                  input is_empty, input is_full, input status, output ready);
endinterface

`default_nettype wire

### design/cdq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/cdq_ctrl.sv
// Controller of the circular deque: sequences accept, slot fetch, load and
// result hand-over. Depends on cdq_pkg.
`default_nettype none

module cdq_ctrl import cdq_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  output cmd_t       cmd,
  input  wire stat_t stat
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        if (stat.need_read) begin
          cmd.rd_en  = 1'b1;
          state_next = S_LOAD;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/cdq_dp.sv
// Datapath of the circular deque: pointers, empty mark, slot store,
// cached front and rear entries and the result register.
// Depends on cdq_pkg, cdq_rsp_if and cdq_ram.
`default_nettype none

module cdq_dp import cdq_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cmd_t                     cmd,
  output stat_t                         stat,
  input  wire logic [FUNC_W-1:0]        req_func,
  input  wire logic signed [WORD_W-1:0] req_value,
  cdq_rsp_if.source                     rsp
);

  ptr_t    head;
  ptr_t    tail;
  logic    empty_mark;
  data_t   front_val;
  data_t   rear_val;
  status_t sts;
  logic    need_read;
  logic    rd_front;
  logic    out_valid;

  func_t   fn;
  data_t   in_data;
  logic    full;
  logic    we;
  ptr_t    waddr;
  ptr_t    raddr;
  data_t   rdata;

  assign fn      = func_t'(req_func);
  assign in_data = DATA_BITS'(req_value);
  assign full    = !empty_mark && (ptr_inc(tail) == head);

  assign we    = cmd.take && !req_func[1] && !full;
  assign waddr = empty_mark ? '0 : ((fn == FN_INS_FRONT) ? ptr_dec(head) : ptr_inc(tail));
  assign raddr = rd_front ? head : tail;

  cdq_ram #(
    .WIDTH (DATA_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_data),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      empty_mark <= 1'b1;
      need_read  <= 1'b0;
    end else if (cmd.take) begin
      need_read <= 1'b0;
      case (fn)
        FN_INS_FRONT, FN_INS_REAR: begin
          if (!full) begin
            if (empty_mark) begin
              head       <= '0;
              tail       <= '0;
              empty_mark <= 1'b0;
            end else if (fn == FN_INS_FRONT) begin
              head <= ptr_dec(head);
            end else begin
              tail <= ptr_inc(tail);
            end
          end
        end
        FN_DEL_FRONT, FN_DEL_REAR: begin
          if (!empty_mark) begin
            if (head == tail) begin
              head       <= '0;
              tail       <= '0;
              empty_mark <= 1'b1;
            end else if (fn == FN_DEL_FRONT) begin
              head      <= ptr_inc(head);
              need_read <= 1'b1;
            end else begin
              tail      <= ptr_dec(tail);
              need_read <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      rd_front <= (fn == FN_DEL_FRONT);
      if (!req_func[1]) begin
        sts <= full ? STS_FULL : STS_DONE;
        if (!full) begin
          if (empty_mark) begin
            front_val <= in_data;
            rear_val  <= in_data;
          end else if (fn == FN_INS_FRONT) begin
            front_val <= in_data;
          end else begin
            rear_val <= in_data;
          end
        end
      end else begin
        sts <= empty_mark ? STS_EMPTY : STS_DONE;
      end
    end else if (cmd.load) begin
      if (rd_front) begin
        front_val <= rdata;
      end else begin
        rear_val <= rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.front_value <= empty_mark ? '1 : WORD_W'(signed'(front_val));
      rsp.rear_value  <= empty_mark ? '1 : WORD_W'(signed'(rear_val));
      rsp.is_empty    <= empty_mark;
      rsp.is_full     <= full;
      rsp.status      <= sts;
    end
  end

  assign rsp.valid      = out_valid;
  assign stat.need_read = need_read;
  assign stat.out_free  = !out_valid || rsp.ready;

endmodule

`default_nettype wire

### design/circular_deque.sv
// Circular deque of DEPTH words held in a ring store with front and rear
// pointers. Depends on cdq_pkg, cdq_req_if, cdq_rsp_if, cdq_ctrl and cdq_dp.
//
// Each request beat carries one operation (insert front, insert rear,
// delete front, delete rear) and returns exactly one response beat with the
// front and rear entries after the operation (all ones when empty), the
// empty and full flags and a status. After a request is accepted, the
// controller passes its fetch state; for a delete that leaves entries it
// then reads the new front or rear entry through the registered read port
// of the slot RAM and takes it in its load state. The result register is
// loaded in the emit state; a response beat still held by the receiver
// delays the load. The next request is accepted in the cycle after the
// load. One request is in progress at a time; a finished result waits in
// the output register while the next request is accepted. The slot store
// needs no clearing after reset.
`default_nettype none

module circular_deque import cdq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  cdq_req_if.sink   req,
  cdq_rsp_if.source rsp
);

  cmd_t  cmd;
  stat_t stat;

  cdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  cdq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req_func  (req.func),
    .req_value (req.value),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

### sim/cdq_result_check.sv
// Checker for the circular deque: watches the request and response channels,
// keeps its own copy of the ring store and pointers, and compares every
// response beat with the expected one. Depends on cdq_pkg and the two channel interfaces.
module cdq_result_check import cdq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  cdq_req_if        req,
  cdq_rsp_if        rsp,
  output int        failures,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [WORD_W-1:0] front_value;
    logic [WORD_W-1:0] rear_value;
    logic              is_empty;
    logic              is_full;
    status_t           status;
  } deque_view_t;

  data_t       ring [DEPTH];
  ptr_t        head;
  ptr_t        tail;
  logic        holds_none;
  deque_view_t expected_views [$];

  function automatic ptr_t step_up(ptr_t p);
    return ptr_t'((int'(p) + 1) % DEPTH);
  endfunction

  function automatic ptr_t step_down(ptr_t p);
    return ptr_t'((int'(p) + DEPTH - 1) % DEPTH);
  endfunction

  function automatic logic [WORD_W-1:0] widen(data_t d);
    return WORD_W'($signed(d));
  endfunction

  function automatic logic ring_full();
    return !holds_none && step_up(tail) == head;
  endfunction

  task automatic apply_op(func_t f, logic [WORD_W-1:0] v);
    deque_view_t view;
    data_t       word;
    view.status = STS_DONE;
    word = data_t'($signed(v));
    if (f == FN_INS_FRONT || f == FN_INS_REAR) begin
      if (ring_full()) begin
        view.status = STS_FULL;
      end else if (holds_none) begin
        head = '0;
        tail = '0;
        holds_none = 1'b0;
        ring[0] = word;
      end else if (f == FN_INS_FRONT) begin
        head = step_down(head);
        ring[head] = word;
      end else begin
        tail = step_up(tail);
        ring[tail] = word;
      end
    end else begin
      if (holds_none) begin
        view.status = STS_EMPTY;
      end else if (head == tail) begin
        head = '0;
        tail = '0;
        holds_none = 1'b1;
      end else if (f == FN_DEL_FRONT) begin
        head = step_up(head);
      end else begin
        tail = step_down(tail);
      end
    end
    view.front_value = holds_none ? '1 : widen(ring[head]);
    view.rear_value  = holds_none ? '1 : widen(ring[tail]);
    view.is_empty    = holds_none;
    view.is_full     = ring_full();
    expected_views.push_back(view);
  endtask

  task automatic compare_field(string name, logic [WORD_W-1:0] want,
                               logic [WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : watch
    deque_view_t want;
    if (rst) begin
      head = '0;
      tail = '0;
      holds_none = 1'b1;
      expected_views.delete();
      failures = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_views.size() == 0) begin
          $error("response beat arrived with no expectation waiting");
          failures++;
        end else begin
          want = expected_views.pop_front();
          compare_field("front_value", want.front_value, rsp.front_value);
          compare_field("rear_value", want.rear_value, rsp.rear_value);
          compare_field("is_empty", WORD_W'(want.is_empty), WORD_W'(rsp.is_empty));
          compare_field("is_full", WORD_W'(want.is_full), WORD_W'(rsp.is_full));
          compare_field("status", WORD_W'(want.status), WORD_W'(rsp.status));
        end
      end
      if (req.valid && req.ready) begin
        apply_op(func_t'(req.func), req.value);
      end
    end
    pending = expected_views.size();
  end
endmodule

### sim/testbench.sv
// Top of the circular deque bench: clock, reset, request stimulus, response
// back-pressure, watchdog and verdict. Depends on cdq_pkg, the channel
// interfaces, circular_deque and cdq_result_check.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cdq_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int CHOKE_CYCLES = 400;
  localparam int LANE_MIXED    = 0;
  localparam int LANE_REAR_IN  = 1;
  localparam int LANE_FRONT_IN = 2;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   failures;
  int   pending;
  bit   req_steady;
  bit   rsp_steady;
  bit   choke_req;

  cdq_req_if req ();
  cdq_rsp_if rsp ();

  circular_deque u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  cdq_result_check u_check (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .failures (failures),
    .pending  (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return {1'b0, {(WORD_W-1){1'b1}}};
      1:       return {1'b1, {(WORD_W-1){1'b0}}};
      2:       return '1;
      3:       return WORD_W'($urandom_range(0, 15));
      default: return WORD_W'($urandom);
    endcase
  endfunction

  task automatic send_op(func_t f, logic [WORD_W-1:0] v);
    int gap;
    gap = pick_gap(req_steady);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.func  <= f;
    req.value <= v;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic run_phase(int count, int ins_pct, int lane);
    func_t f;
    repeat (count) begin
      if ($urandom_range(1, 100) <= ins_pct) begin
        if (lane == LANE_REAR_IN) f = FN_INS_REAR;
        else if (lane == LANE_FRONT_IN) f = FN_INS_FRONT;
        else f = $urandom_range(0, 1) ? FN_INS_REAR : FN_INS_FRONT;
      end else begin
        if (lane == LANE_REAR_IN) f = FN_DEL_FRONT;
        else if (lane == LANE_FRONT_IN) f = FN_DEL_REAR;
        else f = $urandom_range(0, 1) ? FN_DEL_REAR : FN_DEL_FRONT;
      end
      send_op(f, pick_value());
    end
  endtask

  initial begin : responder
    int stall;
    rsp.ready = 1'b0;
    forever begin
      if (choke_req) begin
        choke_req = 1'b0;
        rsp.ready <= 1'b0;
        repeat (CHOKE_CYCLES) @(posedge clk);
      end else begin
        stall = pick_gap(rsp_steady);
        if (stall > 0) begin
          rsp.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        rsp.ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle = 0;
      else idle++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    req.valid = 1'b0;
    req.func  = FN_INS_FRONT;
    req.value = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_op(FN_DEL_FRONT, '1);
    send_op(FN_DEL_REAR, '0);
    send_op(FN_INS_FRONT, {1'b0, {(WORD_W-1){1'b1}}});
    send_op(FN_INS_REAR, {1'b1, {(WORD_W-1){1'b0}}});
    send_op(FN_INS_FRONT, '1);
    send_op(FN_INS_REAR, '0);
    send_op(FN_DEL_FRONT, '0);
    send_op(FN_DEL_REAR, '0);
    send_op(FN_DEL_FRONT, '0);
    send_op(FN_DEL_REAR, '0);
    send_op(FN_DEL_REAR, '0);
    send_op(FN_INS_REAR, WORD_W'(1));
    send_op(FN_DEL_FRONT, '1);
    send_op(FN_INS_FRONT, WORD_W'(32'h5a5a_a5a5));
    send_op(FN_DEL_REAR, '1);
    send_op(FN_INS_REAR, WORD_W'(32'ha5a5_5a5a));
    send_op(FN_INS_FRONT, WORD_W'(32'h0000_8000));

    run_phase(100, 50, LANE_MIXED);
    req_steady = 1'b1;
    choke_req  = 1'b1;
    run_phase(140, 100, LANE_MIXED);
    rsp_steady = 1'b1;
    run_phase(60, 50, LANE_MIXED);
    req_steady = 1'b0;
    rsp_steady = 1'b0;
    run_phase(140, 0, LANE_MIXED);
    run_phase(80, 70, LANE_REAR_IN);
    run_phase(70, 70, LANE_FRONT_IN);
    run_phase(60, 50, LANE_MIXED);

    req.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
